### rtl/core/nlp_pkg.sv
// ----------------------------------------------------------------------------
// nlp_pkg: shared types and constants for the numeric literal parser
// Holds the prefix phase codes, radix and compare codes, status codes and the
// structures that travel between the input stage, the parse core and the top.
// ----------------------------------------------------------------------------
package nlp_pkg;

  // Prefix phase, one-hot.
  typedef enum logic [2:0] {
    PH_FIRST = 3'b001,
    PH_ZERO  = 3'b010,
    PH_BODY  = 3'b100
  } phase_t;

  // Radix codes.
  localparam logic [1:0] RX_BIN = 2'd0;
  localparam logic [1:0] RX_OCT = 2'd1;
  localparam logic [1:0] RX_DEC = 2'd2;
  localparam logic [1:0] RX_HEX = 2'd3;

  // Running compare against the signed 32-bit limit text.
  localparam logic [1:0] CMP_EQ = 2'd0;
  localparam logic [1:0] CMP_GT = 2'd1;
  localparam logic [1:0] CMP_LT = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_INT_OK    = 3'd0;
  localparam logic [2:0] ST_REAL_OK   = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_BAD_DIGIT = 3'd3;
  localparam logic [2:0] ST_NO_DIGITS = 3'd4;
  localparam logic [2:0] ST_MANY_DOTS = 3'd5;
  localparam logic [2:0] ST_BAD_BASE  = 3'd6;

  // Character constants.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_O  = 8'h6f;
  localparam logic [7:0] CH_LC_D  = 8'h64;
  localparam logic [7:0] CH_LC_X  = 8'h78;

  // Length limits for a signed 32-bit integer in each radix.
  localparam logic [5:0] MAX_BIN_LEN = 6'd31;
  localparam logic [5:0] MAX_OCT_LEN = 6'd11;
  localparam logic [5:0] MAX_DEC_LEN = 6'd10;
  localparam logic [5:0] MAX_HEX_LEN = 6'd8;
  localparam logic [5:0] CNT_MAX     = 6'd63;
  localparam logic [1:0] DOTS_MAX    = 2'd2;

  // One input beat held in the input stage.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } beat_t;

  // One finished result.
  typedef struct packed {
    logic [63:0] frac_denominator;
    logic [63:0] frac_numerator;
    logic [63:0] whole_part;
    logic [2:0]  status;
  } result_t;

endpackage

### rtl/core/nlp_in_stage.sv
// ----------------------------------------------------------------------------
// nlp_in_stage: input register of the numeric literal parser
// Captures one character beat and holds it until the parse core takes it.
// ----------------------------------------------------------------------------
module nlp_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,   // [7:0] ch
  input  logic           in_tlast,   // last
  output logic           beat_valid,
  output nlp_pkg::beat_t beat,
  input  logic           beat_ready
);

  logic           valid_r;
  logic           valid_nxt;
  nlp_pkg::beat_t beat_r;

  // The register frees up in the same cycle the core takes its beat.
  assign in_tready  = !valid_r || beat_ready;
  assign beat_valid = valid_r;
  assign beat       = beat_r;

  // Valid flag follows accepts and consumes.
  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (beat_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload loads on accept only.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      beat_r.ch   <= in_tdata;
      beat_r.last <= in_tlast;
    end
  end

endmodule

### rtl/core/nlp_parse_core.sv
// ----------------------------------------------------------------------------
// nlp_parse_core: per-character parse state and result logic
// Updates prefix, counters, compare state and three accumulators for one
// character per cycle unless a last one waits on the output; forms its result.
// ----------------------------------------------------------------------------
module nlp_parse_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             beat_valid,
  input  nlp_pkg::beat_t   beat,
  output logic             beat_ready,
  input  logic             out_free,
  output logic             res_valid,
  output nlp_pkg::result_t res
);

  // Parse state besides the prefix phase.
  typedef struct packed {
    logic [1:0]  radix;
    logic [5:0]  cnt;
    logic [1:0]  dots;
    logic [1:0]  cmp;
    logic [7:0]  lead;
    logic        derr;
    logic        berr;
    logic [63:0] whole;
    logic [63:0] frac;
    logic [63:0] den;
  } pstate_t;

  nlp_pkg::phase_t phase_r;
  nlp_pkg::phase_t phase_nxt;
  pstate_t         st_r;
  pstate_t         st_nxt;
  pstate_t         st_upd;
  logic            step;

  // The limit text "2147483647", one character per position.
  function automatic logic [7:0] limit_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h32;
      4'd1:    c = 8'h31;
      4'd2:    c = 8'h34;
      4'd3:    c = 8'h37;
      4'd4:    c = 8'h34;
      4'd5:    c = 8'h38;
      4'd6:    c = 8'h33;
      4'd7:    c = 8'h36;
      4'd8:    c = 8'h34;
      default: c = 8'h37;
    endcase
    return c;
  endfunction

  // Multiply by the radix with shifts and one add, wrapping at 64 bits.
  function automatic logic [63:0] mul_radix(input logic [63:0] x, input logic [1:0] rx);
    logic [63:0] y;
    unique case (rx)
      nlp_pkg::RX_BIN: y = x << 1;
      nlp_pkg::RX_OCT: y = x << 3;
      nlp_pkg::RX_DEC: y = (x << 3) + (x << 1);
      default:         y = x << 4;
    endcase
    return y;
  endfunction

  // Digit value with a valid flag in bit 4; invalid for the radix gives 0.
  function automatic logic [4:0] digit_of(input logic [7:0] c, input logic [1:0] rx);
    logic [4:0] d;
    logic [4:0] lim;
    d = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b1, c[3:0] - 4'h0};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      d = {1'b1, c[3:0] + 4'd9};
    end
    unique case (rx)
      nlp_pkg::RX_BIN: lim = 5'd2;
      nlp_pkg::RX_OCT: lim = 5'd8;
      nlp_pkg::RX_DEC: lim = 5'd10;
      default:         lim = 5'd16;
    endcase
    if (d[4] && ({1'b0, d[3:0]} >= lim)) begin
      d = 5'd0;
    end
    return d;
  endfunction

  // Effect of one body character on the parse state.
  function automatic pstate_t body_char(input pstate_t s, input logic [7:0] c);
    pstate_t    n;
    logic [4:0] d;
    logic [7:0] lc;
    n  = s;
    d  = digit_of(c, s.radix);
    lc = limit_char(s.cnt[3:0]);
    if (c == nlp_pkg::CH_DOT) begin
      if (s.dots < nlp_pkg::DOTS_MAX) begin
        n.dots = s.dots + 2'd1;
      end
    end else if (c != nlp_pkg::CH_UNDER) begin
      if (!d[4]) begin
        n.derr = 1'b1;
      end else if (s.dots == 2'd0) begin
        n.whole = mul_radix(s.whole, s.radix) + {60'd0, d[3:0]};
      end else if (s.dots == 2'd1) begin
        n.frac = mul_radix(s.frac, s.radix) + {60'd0, d[3:0]};
        n.den  = mul_radix(s.den, s.radix);
      end
      if (s.cnt == 6'd0) begin
        n.lead = c;
      end
      if (s.cnt < 6'd10 && s.cmp == nlp_pkg::CMP_EQ) begin
        if (c > lc) begin
          n.cmp = nlp_pkg::CMP_GT;
        end else if (c < lc) begin
          n.cmp = nlp_pkg::CMP_LT;
        end
      end
      if (s.cnt < nlp_pkg::CNT_MAX) begin
        n.cnt = s.cnt + 6'd1;
      end
    end
    return n;
  endfunction

  // Length and magnitude check for a signed 32-bit integer.
  function automatic logic too_large(input pstate_t s);
    logic t;
    unique case (s.radix)
      nlp_pkg::RX_BIN: t = s.cnt > nlp_pkg::MAX_BIN_LEN;
      nlp_pkg::RX_OCT: t = s.cnt > nlp_pkg::MAX_OCT_LEN ||
                           (s.cnt == nlp_pkg::MAX_OCT_LEN && s.lead > nlp_pkg::CH_ONE);
      nlp_pkg::RX_DEC: t = s.cnt > nlp_pkg::MAX_DEC_LEN ||
                           (s.cnt == nlp_pkg::MAX_DEC_LEN && s.cmp == nlp_pkg::CMP_GT);
      default:         t = s.cnt > nlp_pkg::MAX_HEX_LEN ||
                           (s.cnt == nlp_pkg::MAX_HEX_LEN && s.lead > nlp_pkg::CH_SEVEN);
    endcase
    return t;
  endfunction

  function automatic pstate_t reset_state();
    pstate_t s;
    s       = '0;
    s.radix = nlp_pkg::RX_DEC;
    s.cmp   = nlp_pkg::CMP_EQ;
    s.den   = 64'd1;
    return s;
  endfunction

  // A last character needs a free output slot; others always go.
  assign beat_ready = !beat.last || out_free;
  assign step       = beat_valid && beat_ready;
  assign res_valid  = step && beat.last;

  // Prefix handling and body update for the current character.
  always_comb begin
    phase_nxt = phase_r;
    st_upd    = st_r;
    unique case (phase_r)
      nlp_pkg::PH_FIRST: begin
        if (beat.ch == nlp_pkg::CH_ZERO && !beat.last) begin
          phase_nxt = nlp_pkg::PH_ZERO;
        end else begin
          phase_nxt = nlp_pkg::PH_BODY;
          st_upd    = body_char(st_r, beat.ch);
        end
      end
      nlp_pkg::PH_ZERO: begin
        phase_nxt = nlp_pkg::PH_BODY;
        case (beat.ch)
          nlp_pkg::CH_DOT: begin
            // The leading zero becomes a decimal digit, then the dot counts.
            st_upd      = body_char(st_r, nlp_pkg::CH_ZERO);
            st_upd.dots = 2'd1;
          end
          nlp_pkg::CH_LC_B: st_upd.radix = nlp_pkg::RX_BIN;
          nlp_pkg::CH_LC_O: st_upd.radix = nlp_pkg::RX_OCT;
          nlp_pkg::CH_LC_D: st_upd.radix = nlp_pkg::RX_DEC;
          nlp_pkg::CH_LC_X: st_upd.radix = nlp_pkg::RX_HEX;
          default:          st_upd.berr  = 1'b1;
        endcase
      end
      default: begin
        if (!st_r.berr) begin
          st_upd = body_char(st_r, beat.ch);
        end
      end
    endcase
    // After the last character the next one starts a new literal.
    if (beat.last) begin
      phase_nxt = nlp_pkg::PH_FIRST;
    end
  end

  // Result from the updated state; errors give zero values.
  always_comb begin
    res.status           = nlp_pkg::ST_INT_OK;
    res.whole_part       = 64'd0;
    res.frac_numerator   = 64'd0;
    res.frac_denominator = 64'd0;
    if (st_upd.berr) begin
      res.status = nlp_pkg::ST_BAD_BASE;
    end else if (st_upd.cnt == 6'd0) begin
      res.status = nlp_pkg::ST_NO_DIGITS;
    end else if (st_upd.dots == 2'd0) begin
      if (too_large(st_upd)) begin
        res.status = nlp_pkg::ST_TOO_LARGE;
      end else if (st_upd.derr) begin
        res.status = nlp_pkg::ST_BAD_DIGIT;
      end else begin
        res.status           = nlp_pkg::ST_INT_OK;
        res.whole_part       = st_upd.whole;
        res.frac_denominator = 64'd1;
      end
    end else if (st_upd.dots == 2'd1) begin
      if (st_upd.derr) begin
        res.status = nlp_pkg::ST_BAD_DIGIT;
      end else begin
        res.status           = nlp_pkg::ST_REAL_OK;
        res.whole_part       = st_upd.whole;
        res.frac_numerator   = st_upd.frac;
        res.frac_denominator = st_upd.den;
      end
    end else begin
      res.status = nlp_pkg::ST_MANY_DOTS;
    end
  end

  // The literal ends: start over from the reset state.
  always_comb begin
    st_nxt = st_upd;
    if (beat.last) begin
      st_nxt = reset_state();
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= nlp_pkg::PH_FIRST;
      st_r    <= reset_state();
    end else if (step) begin
      phase_r <= phase_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

### rtl/core/numeric_literal_parser.sv
// ----------------------------------------------------------------------------
// numeric_literal_parser: radix-prefixed numeric literal parser
// Parses a literal one character per beat and delivers one result beat with
// the status, whole part, fraction numerator and fraction denominator.
//
//   Channel  Dir  Beat carries                       Marker
//   in_      in   ch (8 bits)                        in_tlast = last char
//   out_     out  status, whole, numerator, denom.   one beat per literal
//
// One character is taken every cycle unless a last character waits for a free
// output register; the parse state updates once per beat. The last character
// waits in the input register until the output register is free, then its
// result is loaded into the output register, which drives out_tvalid.
// rst_n is synchronous; reset returns the parser to the start of a literal.
// While a result waits on out_tready, characters that are not last still flow.
// ----------------------------------------------------------------------------
module numeric_literal_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] ch
  input  logic         in_tlast,   // last
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [199:0] out_tdata   // [2:0] status, [66:3] whole_part,
                                   // [130:67] frac_numerator,
                                   // [194:131] frac_denominator, [199:195] zero
);

  logic             beat_valid;
  nlp_pkg::beat_t   beat;
  logic             beat_ready;
  logic             out_free;
  logic             res_valid;
  nlp_pkg::result_t res;
  logic             out_valid_r;
  logic             out_valid_nxt;
  nlp_pkg::result_t out_r;

  nlp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_ready (beat_ready)
  );

  nlp_parse_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_ready (beat_ready),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Output register: free when empty or being taken this cycle.
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_r};

endmodule
